>>> sv/rmsn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RMS normalization unit.
// No dependencies; every other file refers to this package by scoped names.
package rmsn_pkg;

    // Defaults for top-level parameters
    localparam int DEF_MAX_LENGTH   = 65536;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Configuration registers
    localparam int LEN_W      = 17;
    localparam int EPS_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 1'b1;

    localparam logic [LEN_W-1:0] RST_VECTOR_LENGTH = 17'd4096;
    localparam logic [EPS_W-1:0] RST_EPSILON       = 16'd17;

    // Accumulator and inverse root
    localparam int SUM_W = 48;
    localparam int INV_W = 32;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Shared restoring divider
    localparam int DVD_W = 73;          // dividend: 2^72 for the reciprocal
    localparam int DVS_W = SUM_W + 1;   // divisor: mean square plus epsilon
    localparam int QUO_W = 64;
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] MEAN_STEPS  = 7'd48;
    localparam logic [CNT_W-1:0] RECIP_STEPS = 7'd73;
    localparam logic [DVD_W-1:0] RECIP_DIVIDEND = {1'b1, {(DVD_W-1){1'b0}}};

    // Mean square at or below this saturates the inverse root
    localparam logic [DVS_W-1:0] TINY_MEAN = 49'd256;

    // Integer square root
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    // Q8.24 inverse root times Q4.12 times Q4.12 back to Q4.12
    localparam int FRAC_SHIFT = 36;

    typedef struct packed {
        logic load_in;      // capture the accepted transaction
        logic mul_mag;      // magnitude product: square or sample times gain
        logic acc_add;      // saturating add into the square sum
        logic div1_start;   // start sum / length, clear the sum
        logic add_eps;      // mean plus epsilon
        logic div2_start;   // start 2^72 / mean
        logic root_start;   // start integer square root of the quotient
        logic store_ones;   // inverse root saturates
        logic store_root;   // inverse root from the root unit
        logic prod_lo;      // low half partial product with inverse root
        logic prod_hi;      // high half partial product with inverse root
        logic prod_sum;     // combine partial products, add rounding half
        logic round;        // scale down and saturate
        logic load_out;     // write the output register
    } t_cmd;

    typedef struct packed {
        logic last;         // captured last_element flag
        logic div_busy;
        logic root_busy;
        logic tiny;         // mean square too small for the reciprocal
    } t_sts;

endpackage

>>> sv/rmsn_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by the mean and
// reciprocal computations. Depends on rmsn_pkg.
module rmsn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rmsn_pkg::DVD_W-1:0]  i_dividend,
    input  logic [rmsn_pkg::DVS_W-1:0]  i_divisor,
    input  logic [rmsn_pkg::CNT_W-1:0]  i_steps,
    output logic [rmsn_pkg::QUO_W-1:0]  o_quotient,
    output logic                        o_busy
);

    logic [rmsn_pkg::DVD_W-1:0] r_dvd;
    logic [rmsn_pkg::DVS_W-1:0] r_dvs;
    logic [rmsn_pkg::DVS_W-1:0] r_rem;
    logic [rmsn_pkg::QUO_W-1:0] r_quo;
    logic [rmsn_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;

    logic [rmsn_pkg::DVS_W:0]   w_rem_sh;
    logic [rmsn_pkg::DVS_W:0]   w_diff;
    logic                       w_fit;
    logic [rmsn_pkg::DVS_W-1:0] n_rem;

    assign w_rem_sh = {r_rem, r_dvd[rmsn_pkg::DVD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};
    assign w_fit    = (w_rem_sh >= {1'b0, r_dvs});
    assign n_rem    = w_fit ? w_diff[rmsn_pkg::DVS_W-1:0] : w_rem_sh[rmsn_pkg::DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == rmsn_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[rmsn_pkg::DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[rmsn_pkg::QUO_W-2:0], w_fit};
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

endmodule

>>> sv/rmsn_isqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on rmsn_pkg.
module rmsn_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rmsn_pkg::RAD_W-1:0]  i_radicand,
    output logic [rmsn_pkg::ROOT_W-1:0] o_root,
    output logic                        o_busy
);

    logic [rmsn_pkg::RAD_W-1:0] r_x;
    logic [rmsn_pkg::RAD_W-1:0] r_r;
    logic [rmsn_pkg::RAD_W-1:0] r_bit;

    logic [rmsn_pkg::RAD_W-1:0] w_trial;
    logic                       w_fit;

    assign w_trial = r_r + r_bit;
    assign w_fit   = (r_x >= w_trial);

    // one-hot test bit doubles as the busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= {2'b01, {(rmsn_pkg::RAD_W-2){1'b0}}};
        end else begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_radicand;
            r_r <= '0;
        end else if (r_bit != '0) begin
            if (w_fit) begin
                r_x <= r_x - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
        end
    end

    assign o_root = r_r[rmsn_pkg::ROOT_W-1:0];
    assign o_busy = (r_bit != '0);

endmodule

>>> sv/rmsn_ctrl.sv
`timescale 1ns / 1ps
// Sequencing controller: handshakes and the command sequence per transaction.
// Depends on rmsn_pkg (t_cmd, t_sts).
module rmsn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_op,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  rmsn_pkg::t_sts   i_sts,
    output rmsn_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQR,
        S_ACC,
        S_DIV1,
        S_DIV1W,
        S_MEAN,
        S_CHK,
        S_DIV2W,
        S_ROOTW,
        S_MSG,
        S_MLO,
        S_MHI,
        S_SUM,
        S_RND,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_op ? S_MSG : S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.mul_mag = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state = i_sts.last ? S_DIV1 : S_OUT;
            end
            S_DIV1: begin
                o_cmd.div1_start = 1'b1;
                n_state = S_DIV1W;
            end
            S_DIV1W: begin
                if (!i_sts.div_busy) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.add_eps = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.tiny) begin
                    o_cmd.store_ones = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.div2_start = 1'b1;
                    n_state = S_DIV2W;
                end
            end
            S_DIV2W: begin
                if (!i_sts.div_busy) begin
                    o_cmd.root_start = 1'b1;
                    n_state = S_ROOTW;
                end
            end
            S_ROOTW: begin
                if (!i_sts.root_busy) begin
                    o_cmd.store_root = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_MSG: begin
                o_cmd.mul_mag = 1'b1;
                n_state = S_MLO;
            end
            S_MLO: begin
                o_cmd.prod_lo = 1'b1;
                n_state = S_MHI;
            end
            S_MHI: begin
                o_cmd.prod_hi = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.prod_sum = 1'b1;
                n_state = S_RND;
            end
            S_RND: begin
                o_cmd.round = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free or drains this cycle
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> sv/rmsn_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, square sum, inverse root, normalize
// products and the output register. Depends on rmsn_pkg, rmsn_div, rmsn_isqrt.
module rmsn_dp #(
    parameter int MAX_LENGTH   = rmsn_pkg::DEF_MAX_LENGTH,
    parameter int SAMPLE_WIDTH = rmsn_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rmsn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rmsn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_op,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_gain,
    input  logic                             i_last_element,
    input  rmsn_pkg::t_cmd                   i_cmd,
    output rmsn_pkg::t_sts                   o_sts,
    output logic signed [SAMPLE_WIDTH-1:0]   o_result_value,
    output logic                             o_is_normalized,
    output logic                             o_result_last,
    output logic                             o_saturated
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int AW  = 2 * SW;                              // magnitude product
    localparam int EW  = ((AW > rmsn_pkg::SUM_W) ? AW : rmsn_pkg::SUM_W) + 1;
    localparam int PW  = SW + rmsn_pkg::INV_W;                // partial product
    localparam int TW  = AW + rmsn_pkg::INV_W + 1;            // rounded total
    localparam int MW  = TW - rmsn_pkg::FRAC_SHIFT;           // scaled magnitude
    localparam logic [TW-1:0] HALF = TW'(1) << (rmsn_pkg::FRAC_SHIFT - 1);
    localparam logic [MW-1:0] MIN_MAG = MW'(1) << (SW - 1);
    localparam logic [SW-1:0] POS_LIMIT = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] NEG_LIMIT = {1'b1, {(SW-1){1'b0}}};
    localparam logic [rmsn_pkg::LEN_W-1:0] LEN_CAP = rmsn_pkg::LEN_W'(MAX_LENGTH);

    // configuration
    logic [rmsn_pkg::LEN_W-1:0] r_len;
    logic [rmsn_pkg::EPS_W-1:0] r_eps;

    // state
    logic [rmsn_pkg::SUM_W-1:0] r_sum;
    logic [rmsn_pkg::INV_W-1:0] r_inv;

    // captured transaction
    logic                       r_op;
    logic                       r_last;
    logic [SW-1:0]              r_smp;
    logic [SW-1:0]              r_smag;
    logic [SW-1:0]              r_gmag;
    logic                       r_neg;

    // working registers
    logic [AW-1:0]              r_a;
    logic [rmsn_pkg::DVS_W-1:0] r_m;
    logic [PW-1:0]              r_plo;
    logic [PW-1:0]              r_phi;
    logic [TW-1:0]              r_total;
    logic [SW-1:0]              r_nval;
    logic                       r_nsat;

    logic [SW-1:0]              w_smp_u;
    logic [SW-1:0]              w_gain_u;
    logic [SW-1:0]              w_mb;
    logic [EW-1:0]              w_sum_ext;
    logic [rmsn_pkg::LEN_W-1:0] w_len;
    logic [SW-1:0]              w_pa;
    logic [PW-1:0]              w_pp;
    logic [MW-1:0]              w_mag;
    logic                       w_over;
    logic                       w_sat;

    logic                       w_div_start;
    logic [rmsn_pkg::DVD_W-1:0] w_dividend;
    logic [rmsn_pkg::DVS_W-1:0] w_divisor;
    logic [rmsn_pkg::CNT_W-1:0] w_steps;
    logic [rmsn_pkg::QUO_W-1:0] w_quo;
    logic                       w_div_busy;
    logic [rmsn_pkg::ROOT_W-1:0] w_root;
    logic                       w_root_busy;

    assign w_smp_u  = i_sample;
    assign w_gain_u = i_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= rmsn_pkg::RST_VECTOR_LENGTH;
            r_eps <= rmsn_pkg::RST_EPSILON;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rmsn_pkg::CFG_VECTOR_LENGTH: r_len <= i_cfg_data[rmsn_pkg::LEN_W-1:0];
                rmsn_pkg::CFG_EPSILON:       r_eps <= i_cfg_data[rmsn_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // length of zero divides as one, above the cap as the cap
    always_comb begin
        if (r_len == '0) begin
            w_len = rmsn_pkg::LEN_W'(1);
        end else if (r_len > LEN_CAP) begin
            w_len = LEN_CAP;
        end else begin
            w_len = r_len;
        end
    end

    assign w_mb      = r_op ? r_gmag : r_smag;
    assign w_sum_ext = EW'(r_sum) + EW'(r_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_inv <= '0;
        end else begin
            if (i_cmd.acc_add) begin
                if (w_sum_ext > EW'(rmsn_pkg::SUM_MAX)) begin
                    r_sum <= rmsn_pkg::SUM_MAX;
                end else begin
                    r_sum <= w_sum_ext[rmsn_pkg::SUM_W-1:0];
                end
            end else if (i_cmd.div1_start) begin
                r_sum <= '0;
            end
            if (i_cmd.store_ones) begin
                r_inv <= '1;
            end else if (i_cmd.store_root) begin
                r_inv <= w_root;
            end
        end
    end

    // divider operands: mean square, then reciprocal of mean plus epsilon
    assign w_div_start = i_cmd.div1_start | i_cmd.div2_start;
    assign w_dividend  = i_cmd.div1_start
                       ? {r_sum, {(rmsn_pkg::DVD_W-rmsn_pkg::SUM_W){1'b0}}}
                       : rmsn_pkg::RECIP_DIVIDEND;
    assign w_divisor   = i_cmd.div1_start ? rmsn_pkg::DVS_W'(w_len) : r_m;
    assign w_steps     = i_cmd.div1_start ? rmsn_pkg::MEAN_STEPS : rmsn_pkg::RECIP_STEPS;

    rmsn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_steps    (w_steps),
        .o_quotient (w_quo),
        .o_busy     (w_div_busy)
    );

    rmsn_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_start),
        .i_radicand (w_quo),
        .o_root     (w_root),
        .o_busy     (w_root_busy)
    );

    // one multiplier for both halves against the inverse root
    assign w_pa = i_cmd.prod_hi ? r_a[AW-1:SW] : r_a[SW-1:0];
    assign w_pp = PW'(w_pa) * PW'(r_inv);

    // round to Q4.12 and clip
    assign w_mag  = r_total[TW-1:rmsn_pkg::FRAC_SHIFT];
    assign w_over = |w_mag[MW-1:SW-1];
    assign w_sat  = w_over && !(r_neg && (w_mag == MIN_MAG));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_op;
            r_last <= i_last_element;
            r_smp  <= w_smp_u;
            r_smag <= w_smp_u[SW-1] ? (~w_smp_u + 1'b1) : w_smp_u;
            r_gmag <= w_gain_u[SW-1] ? (~w_gain_u + 1'b1) : w_gain_u;
            r_neg  <= w_smp_u[SW-1] ^ w_gain_u[SW-1];
        end
        if (i_cmd.mul_mag) begin
            r_a <= AW'(r_smag) * AW'(w_mb);
        end
        if (i_cmd.add_eps) begin
            r_m <= rmsn_pkg::DVS_W'(w_quo[rmsn_pkg::SUM_W-1:0])
                 + rmsn_pkg::DVS_W'(r_eps);
        end
        if (i_cmd.prod_lo) begin
            r_plo <= w_pp;
        end
        if (i_cmd.prod_hi) begin
            r_phi <= w_pp;
        end
        if (i_cmd.prod_sum) begin
            r_total <= (TW'(r_phi) << SW) + TW'(r_plo) + HALF;
        end
        if (i_cmd.round) begin
            r_nsat <= w_sat;
            if (w_sat) begin
                r_nval <= r_neg ? NEG_LIMIT : POS_LIMIT;
            end else begin
                r_nval <= r_neg ? (~w_mag[SW-1:0] + 1'b1) : w_mag[SW-1:0];
            end
        end
        if (i_cmd.load_out) begin
            o_result_value  <= r_op ? r_nval : r_smp;
            o_is_normalized <= r_op;
            o_result_last   <= r_last;
            o_saturated     <= r_op & r_nsat;
        end
    end

    assign o_sts.last      = r_last;
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.root_busy = w_root_busy;
    assign o_sts.tiny      = (r_m <= rmsn_pkg::TINY_MEAN);

endmodule

>>> sv/rms_norm_two_pass_unit.sv
`timescale 1ns / 1ps
// RMS normalization unit, two passes over a token vector, one transaction at a time.
// Accumulate element: square, accumulate, then write the output register; normalize
// element: multiply, two partial products, sum with rounding half, round, then output. The last
// accumulate element also runs the bit-serial divider (48 + 73 steps) and the 32-step square
// root; on a tiny mean only the 48-step mean division. A stalled consumer adds its stall.
// Synchronous active-low reset clears control, square sum, inverse root; config takes defaults.
module rms_norm_two_pass_unit #(
    parameter int MAX_LENGTH   = rmsn_pkg::DEF_MAX_LENGTH,
    parameter int SAMPLE_WIDTH = rmsn_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [rmsn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rmsn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_op,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_gain,
    input  logic                             i_last_element,
    // output channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]   o_result_value,
    output logic                             o_is_normalized,
    output logic                             o_result_last,
    output logic                             o_saturated
);

    rmsn_pkg::t_cmd w_cmd;
    rmsn_pkg::t_sts w_sts;

    // Controller: accepts a transaction only when idle, steps the datapath
    // through the square/accumulate or normalize sequence, and on the last
    // accumulate element runs the mean, then reciprocal and root unless tiny, before releasing.
    rmsn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Datapath: holds configuration, the 48-bit saturating square sum, the
    // Q8.24 inverse root, the shared divider and root units, and the output
    // register that parts the input side from a stalled consumer.
    rmsn_dp #(
        .MAX_LENGTH   (MAX_LENGTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_sample        (i_sample),
        .i_gain          (i_gain),
        .i_last_element  (i_last_element),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_result_value  (o_result_value),
        .o_is_normalized (o_is_normalized),
        .o_result_last   (o_result_last),
        .o_saturated     (o_saturated)
    );

    // One transaction in flight: after an acceptance the input side stalls.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while a transaction is in flight");

    // Never overwrite a result that the consumer has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_valid || !i_stall))
        else $error("output register overwritten while stalled");

    // A residual copy is never flagged as clipped.
    a_residual_unclipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_normalized) |-> !o_saturated)
        else $error("residual copy flagged saturated");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for rms_norm_two_pass_unit: directed and random element streams.
// Holds a scoreboard class with its own fixed-point model; depends on rmsn_pkg and the RTL.

typedef enum bit {OP_ACCUMULATE = 1'b0, OP_NORMALIZE = 1'b1} t_norm_op;

class t_rms_scoreboard;
    localparam int SW = rmsn_pkg::DEF_SAMPLE_WIDTH;

    typedef struct {
        logic signed [SW-1:0] value;
        bit                   normalized;
        bit                   last;
        bit                   clipped;
    } t_norm_out;

    bit [rmsn_pkg::LEN_W-1:0] vec_len;
    bit [rmsn_pkg::EPS_W-1:0] eps;
    bit [rmsn_pkg::SUM_W-1:0] sq_sum;
    bit [rmsn_pkg::INV_W-1:0] inv_root;
    t_norm_out                pending_results[$];
    int errors, n_elements, n_checked, n_norm, n_clipped, n_roots;

    function new();
        vec_len  = rmsn_pkg::RST_VECTOR_LENGTH;
        eps      = rmsn_pkg::RST_EPSILON;
        sq_sum   = '0;
        inv_root = '0;
    endfunction

    function void write_reg(bit [rmsn_pkg::CFG_IDX_W-1:0] idx,
                            bit [rmsn_pkg::CFG_DATA_W-1:0] data);
        if (idx == rmsn_pkg::CFG_VECTOR_LENGTH)
            vec_len = data[rmsn_pkg::LEN_W-1:0];
        else if (idx == rmsn_pkg::CFG_EPSILON)
            eps = data[rmsn_pkg::EPS_W-1:0];
    endfunction

    // floor(sqrt(x)), one root bit per step from the top
    function bit [31:0] int_sqrt(bit [63:0] x);
        bit [31:0] root;
        bit [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= x)
                root = trial;
        end
        return root;
    endfunction

    // 1/sqrt(mean) in Q8.24, i.e. floor(sqrt(floor(2^72 / mean))); all ones for a tiny mean
    function bit [31:0] inverse_root(bit [rmsn_pkg::DVS_W-1:0] mean_sq);
        bit [72:0] dividend;
        bit [63:0] quotient;
        if (mean_sq <= rmsn_pkg::TINY_MEAN)
            return '1;
        dividend = 73'd1 << 72;
        quotient = 64'(dividend / 73'(mean_sq));
        return int_sqrt(quotient);
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // Work out the result of one accepted element and queue it
    function void note_element(t_norm_op op, logic signed [SW-1:0] sample,
                               logic signed [SW-1:0] gain, bit last);
        t_norm_out                  r;
        int                         s, g, prod;
        bit [31:0]                  mag32, sq;
        bit [rmsn_pkg::SUM_W-1:0]   divisor;
        bit [rmsn_pkg::DVS_W-1:0]   mean_sq;
        bit [63:0]                  total, mag, limit;
        bit                         neg;
        s = int'(sample);
        g = int'(gain);
        r.normalized = op;
        r.last       = last;
        r.clipped    = 1'b0;
        n_elements++;
        if (op == OP_ACCUMULATE) begin
            mag32 = (s < 0) ? -s : s;
            sq    = mag32 * mag32;
            if (48'(sq) > rmsn_pkg::SUM_MAX - sq_sum)
                sq_sum = rmsn_pkg::SUM_MAX;
            else
                sq_sum = sq_sum + 48'(sq);
            r.value = sample;
            if (last) begin
                if (vec_len == 0)
                    divisor = rmsn_pkg::SUM_W'(1);
                else if (vec_len > rmsn_pkg::DEF_MAX_LENGTH)
                    divisor = rmsn_pkg::SUM_W'(rmsn_pkg::DEF_MAX_LENGTH);
                else
                    divisor = rmsn_pkg::SUM_W'(vec_len);
                mean_sq  = 49'(sq_sum / divisor) + 49'(eps);
                inv_root = inverse_root(mean_sq);
                sq_sum   = '0;
                n_roots++;
            end
        end else begin
            prod  = s * g;
            neg   = prod < 0;
            mag32 = neg ? -prod : prod;
            total = 64'(mag32) * 64'(inv_root) + (64'd1 << (rmsn_pkg::FRAC_SHIFT - 1));
            mag   = total >> rmsn_pkg::FRAC_SHIFT;
            limit = neg ? (64'd1 << (SW - 1)) : (64'd1 << (SW - 1)) - 64'd1;
            if (mag > limit) begin
                mag       = limit;
                r.clipped = 1'b1;
            end
            r.value = neg ? -mag[SW-1:0] : mag[SW-1:0];
        end
        pending_results.push_back(r);
    endfunction

    function void check_result(logic signed [SW-1:0] value, logic normalized,
                               logic last, logic clipped);
        t_norm_out want;
        if (pending_results.size() == 0) begin
            $display("%0t: result value %0d arrived with nothing outstanding", $time, value);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (value !== want.value) begin
            $display("%0t: result_value expected %0d actual %0d", $time, want.value, value);
            errors++;
        end
        if (normalized !== want.normalized) begin
            $display("%0t: is_normalized expected %0b actual %0b",
                     $time, want.normalized, normalized);
            errors++;
        end
        if (last !== want.last) begin
            $display("%0t: result_last expected %0b actual %0b", $time, want.last, last);
            errors++;
        end
        if (clipped !== want.clipped) begin
            $display("%0t: saturated expected %0b actual %0b", $time, want.clipped, clipped);
            errors++;
        end
        n_checked++;
        if (want.normalized) n_norm++;
        if (want.clipped) n_clipped++;
    endfunction
endclass

module testbench;
    localparam int SW = rmsn_pkg::DEF_SAMPLE_WIDTH;
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    // Long receiver hold-off and the no-progress limit of the watchdog
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    // Margin after the last result
    localparam int END_CYCLES    = 250;
    localparam int SETTLE_CYCLES = 4;
    localparam int BLOCK_ITEMS   = 138;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rmsn_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rmsn_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_valid;
    logic                            o_stall;
    logic                            i_op;
    logic signed [SW-1:0]            i_sample;
    logic signed [SW-1:0]            i_gain;
    logic                            i_last_element;
    logic                            o_valid;
    logic                            i_stall;
    logic signed [SW-1:0]            o_result_value;
    logic                            o_is_normalized;
    logic                            o_result_last;
    logic                            o_saturated;

    t_rms_scoreboard sb;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int n_settings   = 0;
    int idle_cycles  = 0;
    bit hold_pending = 1'b0;

    rms_norm_two_pass_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_sample        (i_sample),
        .i_gain          (i_gain),
        .i_last_element  (i_last_element),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_value  (o_result_value),
        .o_is_normalized (o_is_normalized),
        .o_result_last   (o_result_last),
        .o_saturated     (o_saturated)
    );

    always #2 i_clk = ~i_clk;

    // Monitor: sample pre-edge values at each rising edge. Note the accepted
    // transaction first, so a result is always checked against an older one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_idx, i_cfg_data);
            if (i_valid && o_stall === 1'b0)
                sb.note_element(t_norm_op'(i_op), i_sample, i_gain, i_last_element);
            if (o_valid === 1'b1 && !i_stall)
                sb.check_result(o_result_value, o_is_normalized, o_result_last,
                                o_saturated);
        end
    end

    // Watchdog: count cycles in which no transaction moves on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall, or a long counted hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Offer one element, with random idle cycles ahead of it; return at the
    // edge where it is accepted. Drop valid only while idling.
    task automatic send_element(t_norm_op op, logic signed [SW-1:0] sample,
                                logic signed [SW-1:0] gain, bit last);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_sample       <= sample;
        i_gain         <= gain;
        i_last_element <= last;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges; the spare data bit above
    // epsilon gets random junk, which the block must drop
    task automatic set_config(bit [rmsn_pkg::LEN_W-1:0] len, bit [rmsn_pkg::EPS_W-1:0] eps);
        bit junk;
        junk = 1'($urandom_range(1));
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= rmsn_pkg::CFG_VECTOR_LENGTH;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_idx  <= rmsn_pkg::CFG_EPSILON;
        i_cfg_data <= {junk, eps};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        n_settings++;
    endtask

    // Mostly full-range values, with extremes and small magnitudes mixed in
    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return SW'($urandom_range(0, 600)) - SW'(300);
            default: return SW'($urandom);
        endcase
    endfunction

    initial begin
        int sent;
        int n_vec;
        int k;
        bit [rmsn_pkg::LEN_W-1:0] len;
        bit [rmsn_pkg::EPS_W-1:0] eps;

        sb             = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = rmsn_pkg::CFG_VECTOR_LENGTH;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_op           = OP_ACCUMULATE;
        i_sample       = '0;
        i_gain         = '0;
        i_last_element = 1'b0;
        i_stall        = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part, sender idles little and receiver a lot ----
        snd_idle_pct = 7;
        rcv_idle_pct = 69;

        // Normalize before any accumulate: inverse root is still zero
        send_element(OP_NORMALIZE, S_MAX, S_MAX, 1'b1);
        // Reset settings, extreme samples and gains
        send_element(OP_ACCUMULATE, S_MIN, S_MAX, 1'b0);
        send_element(OP_ACCUMULATE, S_MAX, S_MIN, 1'b0);
        send_element(OP_ACCUMULATE, '0, '0, 1'b0);
        send_element(OP_ACCUMULATE, SW'(-1), SW'(-1), 1'b1);
        send_element(OP_NORMALIZE, S_MAX, S_MAX, 1'b0);
        send_element(OP_NORMALIZE, S_MIN, SW'(4096), 1'b0);
        send_element(OP_NORMALIZE, SW'(-1), S_MIN, 1'b0);
        send_element(OP_NORMALIZE, SW'(12345), SW'(-4096), 1'b1);
        settle();

        // Mean of exactly 2^24 gives an inverse root of 1.0: probe rounding ties
        set_config(rmsn_pkg::LEN_W'(1), '0);
        send_element(OP_ACCUMULATE, SW'(4096), '0, 1'b1);
        send_element(OP_NORMALIZE, SW'(1), SW'(2048), 1'b0);
        send_element(OP_NORMALIZE, SW'(-1), SW'(2048), 1'b0);
        send_element(OP_NORMALIZE, SW'(1), SW'(2047), 1'b0);
        send_element(OP_NORMALIZE, SW'(3), SW'(2048), 1'b1);
        // Tiny mean at the boundary (256), then zero mean
        send_element(OP_ACCUMULATE, SW'(16), '0, 1'b1);
        send_element(OP_NORMALIZE, S_MAX, S_MAX, 1'b0);
        send_element(OP_NORMALIZE, S_MIN, S_MAX, 1'b1);
        send_element(OP_ACCUMULATE, '0, S_MIN, 1'b1);
        settle();

        // Mean one above the tiny boundary
        set_config(rmsn_pkg::LEN_W'(1), rmsn_pkg::EPS_W'(1));
        send_element(OP_ACCUMULATE, SW'(16), '0, 1'b1);
        send_element(OP_NORMALIZE, S_MIN, S_MIN, 1'b1);
        settle();

        // Length above the maximum, largest epsilon
        set_config({rmsn_pkg::LEN_W{1'b1}}, {rmsn_pkg::EPS_W{1'b1}});
        send_element(OP_ACCUMULATE, S_MIN, '0, 1'b0);
        send_element(OP_ACCUMULATE, S_MAX, '0, 1'b1);
        send_element(OP_NORMALIZE, SW'(20000), SW'(-30000), 1'b1);
        settle();

        // Zero length divides as one
        set_config('0, '0);
        send_element(OP_ACCUMULATE, S_MIN, '0, 1'b1);
        send_element(OP_NORMALIZE, S_MIN, S_MIN, 1'b1);
        settle();

        // ---- random part: six settings, idling pattern changes every two ----
        for (int blk = 0; blk < 6; blk++) begin
            case (blk)
                0: begin
                    len = rmsn_pkg::LEN_W'($urandom_range(1, 16));
                    eps = rmsn_pkg::EPS_W'($urandom_range(0, 65535));
                end
                1: begin
                    len = '0;
                    eps = '1;
                end
                2: begin
                    len = rmsn_pkg::LEN_W'(rmsn_pkg::DEF_MAX_LENGTH);
                    eps = '0;
                end
                3: begin
                    len = {rmsn_pkg::LEN_W{1'b1}};
                    eps = rmsn_pkg::EPS_W'($urandom_range(0, 1000));
                end
                4: begin
                    len = rmsn_pkg::LEN_W'($urandom_range(1, 4));
                    eps = '0;
                end
                default: begin
                    len = rmsn_pkg::LEN_W'($urandom_range(0, 131071));
                    eps = rmsn_pkg::EPS_W'($urandom_range(0, 65535));
                end
            endcase
            if (blk < 2) begin
                snd_idle_pct = 7;
                rcv_idle_pct = 69;
            end else if (blk < 4) begin
                snd_idle_pct = 69;
                rcv_idle_pct = 7;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            set_config(len, eps);
            // Hold the receiver off for a long stretch while elements keep coming
            if (blk == 4)
                hold_pending = 1'b1;
            sent = 0;
            while (sent < BLOCK_ITEMS) begin
                if ($urandom_range(99) < 80) begin
                    // Well-formed vector: accumulate pass, then normalize pass
                    n_vec = $urandom_range(1, 8);
                    for (k = 0; k < n_vec; k++)
                        send_element(OP_ACCUMULATE, rand_sample(), rand_sample(),
                                     k == n_vec - 1);
                    for (k = 0; k < n_vec; k++)
                        send_element(OP_NORMALIZE, rand_sample(), rand_sample(),
                                     k == n_vec - 1);
                    sent += 2 * n_vec;
                end else begin
                    // Noise: any op, last set at random
                    send_element(t_norm_op'($urandom_range(1)), rand_sample(), rand_sample(),
                                 $urandom_range(3) == 0);
                    sent++;
                end
            end
            settle();
        end

        // ---- drain and report ----
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Covered %0d elements: %0d results checked, %0d normalized, %0d clipped,",
                 sb.n_elements, sb.n_checked, sb.n_norm, sb.n_clipped);
        $display("%0d inverse roots over %0d register settings, with a long receiver hold-off",
                 sb.n_roots, n_settings);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
